/* hw/rtl/hot_pkg.sv */
package hot_pkg;

  localparam int COORD_BITS_DEF  = 20;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int VEC_W           = 60;

  // 0.0001 in squared real units, as an integer scale on (2*h)^2
  localparam longint DEG_SCALE = 40000;

  localparam logic [1:0] SHAPE_SPHERE  = 2'd0;
  localparam logic [1:0] SHAPE_CAPSULE = 2'd1;

  // pair test selected by the front end
  typedef enum logic [1:0] {
    OP_SS   = 2'd0,  // sphere against sphere
    OP_SC   = 2'd1,  // sphere against capsule
    OP_SB   = 2'd2,  // sphere against box
    OP_AABB = 2'd3   // bounds overlap
  } op_t;

  // queue entry: op, two shapes, two centers (coord+1 bits), two sizes (coord bits)
  function automatic int entry_width(input int coord);
    return 6 + 6 * (coord + 1) + 6 * coord;
  endfunction

  // smallest |h| that is not a degenerate capsule: t*t*40000 >= 2^(2*frac)
  function automatic int deg_limit(input int frac);
    longint lim;
    int     t;
    lim = longint'(1) << (2 * frac);
    t   = 0;
    for (int i = 0; i < 64; i++) begin
      if (longint'(i) * longint'(i) * DEG_SCALE < lim) begin
        t = i + 1;
      end
    end
    return t;
  endfunction

endpackage

/* hw/rtl/hot_if.sv */
interface hot_in_if;
  logic        valid;
  logic        ready;
  logic [59:0] pos_a;
  logic [59:0] offset_a;
  logic [59:0] size_a;
  logic [1:0]  shape_a;
  logic [59:0] pos_b;
  logic [59:0] offset_b;
  logic [59:0] size_b;
  logic [1:0]  shape_b;

  modport source (
    output valid, pos_a, offset_a, size_a, shape_a, pos_b, offset_b, size_b, shape_b,
    input  ready
  );
  modport sink (
    input  valid, pos_a, offset_a, size_a, shape_a, pos_b, offset_b, size_b, shape_b,
    output ready
  );
endinterface

interface hot_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

/* hw/rtl/hot_front.sv */
module hot_front #(
  parameter int COORD_BITS = hot_pkg::COORD_BITS_DEF
) (
  hot_in_if.sink                                      in_chan,
  input  logic                                        q_ready,
  output logic                                        q_valid,
  output logic [hot_pkg::entry_width(COORD_BITS)-1:0] q_data
);
  import hot_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int CT = C + 1;

  logic [2:0][C-1:0]  pa, oa, sa, pb, ob, sb;
  logic [2:0][CT-1:0] ca, cb;
  logic [1:0]         ka, kb, oth;
  logic               swap;
  op_t                op;
  logic [1:0]         s_shape, c_shape;
  logic [2:0][CT-1:0] s_ctr, c_ctr;
  logic [2:0][C-1:0]  s_sz, c_sz;

  // unpack x,y,z and form world centers
  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign pa[k] = in_chan.pos_a[k*C +: C];
    assign oa[k] = in_chan.offset_a[k*C +: C];
    assign sa[k] = in_chan.size_a[k*C +: C];
    assign pb[k] = in_chan.pos_b[k*C +: C];
    assign ob[k] = in_chan.offset_b[k*C +: C];
    assign sb[k] = in_chan.size_b[k*C +: C];
    assign ca[k] = {pa[k][C-1], pa[k]} + {oa[k][C-1], oa[k]};
    assign cb[k] = {pb[k][C-1], pb[k]} + {ob[k][C-1], ob[k]};
  end

  assign ka = in_chan.shape_a;
  assign kb = in_chan.shape_b;

  // put the sphere first whenever one side is a sphere
  always_comb begin
    swap = (ka != SHAPE_SPHERE) && (kb == SHAPE_SPHERE);
    oth  = swap ? ka : kb;
    op   = OP_AABB;
    if ((ka == SHAPE_SPHERE) || (kb == SHAPE_SPHERE)) begin
      case (oth)
        SHAPE_SPHERE:  op = OP_SS;
        SHAPE_CAPSULE: op = OP_SC;
        default:       op = OP_SB;
      endcase
    end
  end

  always_comb begin
    s_shape = swap ? kb : ka;
    c_shape = swap ? ka : kb;
    s_ctr   = swap ? cb : ca;
    c_ctr   = swap ? ca : cb;
    s_sz    = swap ? sb : sa;
    c_sz    = swap ? sa : sb;
  end

  assign q_data        = {op, s_shape, c_shape, s_ctr, s_sz, c_ctr, c_sz};
  assign q_valid       = in_chan.valid;
  assign in_chan.ready = q_ready;

endmodule

/* hw/rtl/hot_queue.sv */
module hot_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_pop,
  output logic [WIDTH-1:0] out_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

/* hw/rtl/hot_back.sv */
module hot_back #(
  parameter int COORD_BITS = hot_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = hot_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_valid,
  output logic                                        q_pop,
  input  logic [hot_pkg::entry_width(COORD_BITS)-1:0] q_data,
  hot_out_if.source                                   out_chan
);
  import hot_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int CT      = C + 1;
  localparam int E2      = C + 2;
  localparam int D       = C + 3;
  localparam int SW      = 2 * D + 2;
  localparam int DEG_LIM = deg_limit(FRAC_BITS);

  function automatic logic signed [E2-1:0] clamp_w(input logic signed [E2-1:0] v,
                                                    input logic signed [E2-1:0] lo,
                                                    input logic signed [E2-1:0] hi);
    logic signed [E2-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // half extents of the bounds of one shape
  function automatic logic [2:0][E2-1:0] extents(input logic [1:0] shp,
                                                  input logic [2:0][C-1:0] sz);
    logic signed [E2-1:0] x, y, z;
    logic [2:0][E2-1:0]   e;
    x = E2'($signed(sz[0]));
    y = E2'($signed(sz[1]));
    z = E2'($signed(sz[2]));
    case (shp)
      SHAPE_SPHERE:  e = {x, x, x};
      SHAPE_CAPSULE: e = {x, y + x, x};
      default:       e = {z, y, x};
    endcase
    return e;
  endfunction

  logic [1:0]         op_bits, s_shape, c_shape;
  op_t                op;
  logic [2:0][CT-1:0] s_ctr, c_ctr;
  logic [2:0][C-1:0]  s_sz, c_sz;

  assign {op_bits, s_shape, c_shape, s_ctr, s_sz, c_ctr, c_sz} = q_data;
  assign op = op_t'(op_bits);

  logic signed [E2-1:0] sc [3];
  logic signed [E2-1:0] cc [3];
  logic signed [E2-1:0] csz [3];
  logic signed [E2-1:0] q [3];
  logic signed [E2-1:0] p [3];
  logic signed [D-1:0]  d [3];
  logic signed [E2-1:0] h, ah, cap_y;
  logic signed [CT-1:0] rt;
  logic [2:0][E2-1:0]   ea, eb;
  logic                 aabb_hit;

  for (genvar k = 0; k < 3; k++) begin : g_ext
    assign sc[k]  = E2'($signed(s_ctr[k]));
    assign cc[k]  = E2'($signed(c_ctr[k]));
    assign csz[k] = E2'($signed(c_sz[k]));
    assign q[k]   = clamp_w(sc[k], cc[k] - csz[k], cc[k] + csz[k]);
    assign d[k]   = D'(p[k]) - D'(sc[k]);
  end

  // capsule: clamp to the vertical segment; if degenerate, use its end at y - h
  always_comb begin
    h  = csz[1];
    ah = (h < 0) ? -h : h;
    if (ah < E2'(DEG_LIM)) begin
      cap_y = cc[1] - h;
    end else begin
      cap_y = clamp_w(sc[1], cc[1] - ah, cc[1] + ah);
    end
  end

  always_comb begin
    case (op)
      OP_SC: begin
        p[0] = cc[0];
        p[1] = cap_y;
        p[2] = cc[2];
      end
      OP_SB: begin
        p[0] = q[0];
        p[1] = q[1];
        p[2] = q[2];
      end
      default: begin
        p[0] = cc[0];
        p[1] = cc[1];
        p[2] = cc[2];
      end
    endcase
    if (op == OP_SB) begin
      rt = CT'($signed(s_sz[0]));
    end else begin
      rt = CT'($signed(s_sz[0])) + CT'($signed(c_sz[0]));
    end
  end

  always_comb begin
    ea       = extents(s_shape, s_sz);
    eb       = extents(c_shape, c_sz);
    aabb_hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ((sc[k] - $signed(ea[k])) > (cc[k] + $signed(eb[k])) ||
          (sc[k] + $signed(ea[k])) < (cc[k] - $signed(eb[k]))) begin
        aabb_hit = 1'b0;
      end
    end
  end

  // three stages under one enable: differences, squares, sum and compare
  logic                 adv;
  logic                 v1_r, v2_r, out_valid_r;
  logic                 aabb1_r, ahit1_r, aabb2_r, ahit2_r, hit_r;
  logic signed [D-1:0]  d1_r [3];
  logic signed [CT-1:0] rt1_r;
  logic [2*D-1:0]       sq2_r [3];
  logic [2*CT-1:0]      rsq2_r;
  logic signed [2*D-1:0]  sq [3];
  logic signed [2*CT-1:0] rsq;
  logic [SW-1:0]        dsum;
  logic                 hit_nxt;

  assign adv   = !out_valid_r || out_chan.ready;
  assign q_pop = adv;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    assign sq[k] = d1_r[k] * d1_r[k];
  end
  assign rsq = rt1_r * rt1_r;

  always_comb begin
    dsum    = SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);
    hit_nxt = aabb2_r ? ahit2_r : (dsum <= SW'(rsq2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aabb1_r <= (op == OP_AABB);
      ahit1_r <= aabb_hit;
      rt1_r   <= rt;
      for (int k = 0; k < 3; k++) begin
        d1_r[k]  <= d[k];
        sq2_r[k] <= sq[k];
      end
      aabb2_r <= aabb1_r;
      ahit2_r <= ahit1_r;
      rsq2_r  <= rsq;
      hit_r   <= hit_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.hit   = hit_r;

endmodule

/* hw/rtl/hitbox_overlap_test_top.sv */
// Hitbox overlap test engine.
//
// in_chan carries one pair of hitboxes per beat: position, offset, size
// (packed x,y,z, signed fixed point) and shape code for each side. out_chan
// returns one beat per input beat with hit = 1 when the pair overlaps.
// Results come back in input order.
//
// A beat accepted into the queue passes the difference, square and
// sum-and-compare registers before its result appears. Throughput: one pair
// per cycle while out_chan.ready stays high; the rate is set by the back-end
// pipeline, which advances one entry every cycle the output register is free.
//
// The front end classifies the pair and writes it into a short queue; the
// back end pulls from the queue. When the receiver holds out_chan.ready low,
// the back end stalls, the queue fills and in_chan.ready drops once it is
// full. Nothing is lost or repeated while stalled.
//
// Reset (rst_n low, synchronous) empties the queue and the pipeline; the
// block accepts beats once reset is released.
module hitbox_overlap_test_top #(
  parameter int COORD_BITS  = hot_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = hot_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = hot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hot_in_if.sink    in_chan,
  hot_out_if.source out_chan
);
  import hot_pkg::*;

  localparam int EW = entry_width(COORD_BITS);

  // front end to queue
  logic          fq_valid, fq_ready;
  logic [EW-1:0] fq_data;
  // queue to back end
  logic          qb_valid, qb_pop;
  logic [EW-1:0] qb_data;

  // classify the pair, form world centers
  hot_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_chan (in_chan),
    .q_ready (fq_ready),
    .q_valid (fq_valid),
    .q_data  (fq_data)
  );

  // hold classified pairs so a stalled back end does not block acceptance at once
  hot_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_pop   (qb_pop),
    .out_data  (qb_data)
  );

  // clamp, square, compare or test bounds; drive the result register
  hot_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (qb_valid),
    .q_pop    (qb_pop),
    .q_data   (qb_data),
    .out_chan (out_chan)
  );

endmodule
